// File: sv/fbds_pkg.sv
// Shared types and constants for the fractional baud divisor search.
package fbds_pkg;

  localparam int unsigned SAMPLE_SHIFT = 4;
  localparam logic [31:0] CLOCK_RESET = 32'd60000000;
  localparam logic [28:0] WIDE_LIMIT = 29'd65535;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVQ,
    S_WQ,
    S_DIVB,
    S_WB,
    S_DIVR,
    S_WR,
    S_DIVA,
    S_WA,
    S_CMP,
    S_STEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

// File: sv/fbds_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module fbds_div (
  input  logic                clk,
  input  logic                rst,
  input  fbds_pkg::div_req_t  req,
  input  logic [31:0]         num,
  input  logic [31:0]         den,
  output fbds_pkg::div_rsp_t  rsp,
  output logic [31:0]         quo
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, quo[31]};
  assign fits = rem_sh >= {1'b0, dsr};
  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= 32'(rem_sh - {1'b0, dsr});
      end else begin
        rem <= rem_sh[31:0];
      end
      quo <= {quo[30:0], fits};
    end
  end

endmodule

// File: sv/fractional_baud_divisor_search.sv
// Top level of the fractional baud divisor search with its sequencer.
//
// Channel | Signals                                   | Word
// in      | in_valid, in_ready, requested_baud        | requested rate
// out     | out_valid, out_ready, divisor, multiplier,| chosen divisor setting
//         | add_value, rate_error, divisor_too_wide   |
// cfg     | cfg_valid, cfg_ready, clock_hz            | peripheral clock in hertz
//
// One word is worked through on the single shared divider: one division for
// the base quotient, then per pair one for the base divisor and two for each
// of the two trial divisors that is not zero.
// A requested rate of zero goes from idle straight to the done state.
// Reset returns to idle and loads the clock register with 60000000.
// A result waiting on out_ready holds the block; no input word is taken then.
module fractional_baud_divisor_search #(
  parameter int unsigned MAX_MULTIPLIER = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] requested_baud,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [27:0] divisor,
  output logic [3:0]  multiplier,
  output logic [3:0]  add_value,
  output logic [23:0] rate_error,
  output logic        divisor_too_wide,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] clock_hz
);

  localparam logic [3:0] MUL_MAX = 4'(MAX_MULTIPLIER);
  localparam logic [3:0] ADD_MAX = 4'(MAX_MULTIPLIER - 1);

  fbds_pkg::state_t   state, state_next;
  fbds_pkg::div_req_t dreq;
  fbds_pkg::div_rsp_t drsp;

  logic [31:0] clk_reg;
  logic [23:0] want;
  logic [27:0] q0;
  logic [27:0] r1;
  logic [31:0] rate;
  logic [3:0]  a;
  logic [3:0]  m;
  logic [28:0] base;
  logic [28:0] d;
  logic        second;
  logic [28:0] best_div;
  logic [3:0]  best_mul;
  logic [3:0]  best_add;
  logic [23:0] best_err;

  logic [31:0] num;
  logic [31:0] den;
  logic [31:0] quo;
  logic [4:0]  msum;
  logic [31:0] diff;
  logic [27:0] clk_sc;

  assign clk_sc = clk_reg[31:fbds_pkg::SAMPLE_SHIFT];
  assign msum = {1'b0, m} + {1'b0, a};
  assign diff = (rate > {8'd0, want}) ? rate - {8'd0, want} : {8'd0, want} - rate;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == fbds_pkg::S_IDLE);
  assign out_valid = (state == fbds_pkg::S_DONE);
  assign divisor = best_div[27:0];
  assign multiplier = best_mul;
  assign add_value = best_add;
  assign rate_error = best_err;
  assign divisor_too_wide = best_div > fbds_pkg::WIDE_LIMIT;

  fbds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .num (num),
    .den (den),
    .rsp (drsp),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fbds_pkg::S_IDLE;
      clk_reg <= fbds_pkg::CLOCK_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        clk_reg <= clock_hz;
      end
    end
  end

  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    num = {4'd0, clk_sc};
    den = {8'd0, want};
    case (state)
      fbds_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (requested_baud == 24'd0) ? fbds_pkg::S_DONE : fbds_pkg::S_DIVQ;
        end
      end
      fbds_pkg::S_DIVQ: begin
        dreq.start = 1'b1;
        state_next = fbds_pkg::S_WQ;
      end
      fbds_pkg::S_WQ: begin
        if (drsp.done) begin
          state_next = fbds_pkg::S_DIVB;
        end
      end
      fbds_pkg::S_DIVB: begin
        dreq.start = 1'b1;
        num = {4'd0, q0} * {28'd0, m};
        den = {27'd0, msum};
        state_next = fbds_pkg::S_WB;
      end
      fbds_pkg::S_WB: begin
        if (drsp.done) begin
          state_next = fbds_pkg::S_DIVR;
        end
      end
      fbds_pkg::S_DIVR: begin
        if (d == 29'd0) begin
          state_next = fbds_pkg::S_STEP;
        end else begin
          dreq.start = 1'b1;
          den = {3'd0, d};
          state_next = fbds_pkg::S_WR;
        end
      end
      fbds_pkg::S_WR: begin
        if (drsp.done) begin
          state_next = fbds_pkg::S_DIVA;
        end
      end
      fbds_pkg::S_DIVA: begin
        dreq.start = 1'b1;
        num = {4'd0, r1} * {28'd0, m};
        den = {27'd0, msum};
        state_next = fbds_pkg::S_WA;
      end
      fbds_pkg::S_WA: begin
        if (drsp.done) begin
          state_next = fbds_pkg::S_CMP;
        end
      end
      fbds_pkg::S_CMP: begin
        state_next = fbds_pkg::S_STEP;
      end
      fbds_pkg::S_STEP: begin
        if (!second) begin
          state_next = fbds_pkg::S_DIVR;
        end else if (m == MUL_MAX && a == ADD_MAX) begin
          state_next = fbds_pkg::S_DONE;
        end else begin
          state_next = fbds_pkg::S_DIVB;
        end
      end
      fbds_pkg::S_DONE: begin
        if (out_ready) begin
          state_next = fbds_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fbds_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      fbds_pkg::S_IDLE: begin
        want     <= requested_baud;
        best_err <= requested_baud;
        best_div <= '0;
        best_mul <= 4'd1;
        best_add <= 4'd0;
        a        <= 4'd0;
        m        <= 4'd1;
      end
      fbds_pkg::S_WQ: begin
        if (drsp.done) begin
          q0 <= quo[27:0];
        end
      end
      fbds_pkg::S_WB: begin
        if (drsp.done) begin
          base   <= quo[28:0];
          d      <= quo[28:0];
          second <= 1'b0;
        end
      end
      fbds_pkg::S_WR: begin
        if (drsp.done) begin
          r1 <= quo[27:0];
        end
      end
      fbds_pkg::S_WA: begin
        if (drsp.done) begin
          rate <= quo;
        end
      end
      fbds_pkg::S_CMP: begin
        if (diff < {8'd0, best_err}) begin
          best_err <= diff[23:0];
          best_div <= d;
          best_mul <= m;
          best_add <= a;
        end
      end
      fbds_pkg::S_STEP: begin
        if (!second) begin
          second <= 1'b1;
          d      <= base + 29'd1;
        end else if (m == MUL_MAX) begin
          a <= a + 4'd1;
          m <= a + 4'd2;
        end else begin
          m <= m + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/fbds_chk.sv
// Port-level checker for the fractional baud divisor search and its bind.
module fbds_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [23:0] requested_baud,
  input logic        out_valid,
  input logic        out_ready,
  input logic [27:0] divisor,
  input logic [3:0]  multiplier,
  input logic [3:0]  add_value,
  input logic [23:0] rate_error,
  input logic        divisor_too_wide,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [31:0] clock_hz
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(divisor) && $stable(rate_error))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid || requested_baud == 24'd0 || $past(requested_baud) == 24'd0)
    else $error("nonzero request finished in one cycle");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> multiplier > add_value)
    else $error("multiplier not above add value");

  a_no_winner: assert property (@(posedge clk) disable iff (rst)
    out_valid && divisor == 28'd0 && !divisor_too_wide |-> multiplier == 4'd1 && add_value == 4'd0)
    else $error("zero divisor with a nonstart pair");

endmodule

bind fractional_baud_divisor_search fbds_chk u_fbds_chk (.*);
